// ----- hw/rtl/rwfrk_pkg.sv -----
// shared types, constants and saturating arithmetic for the friction rk3 cell update
// no dependencies; imported by every module of the block
package rwfrk_pkg;

    localparam int W  = 48;
    localparam int F  = 36;
    localparam int W2 = 2 * W;
    localparam int H  = W / 2;
    localparam int QB = W2 - F + 1;
    localparam int QD = W + 1;
    localparam int XL = QD - F;

    typedef logic signed [W-1:0] t_word;
    typedef logic [W-2:0]        t_ureg;

    localparam t_word MAXV = {1'b0, {(W-1){1'b1}}};
    localparam t_word MINV = {1'b1, {(W-1){1'b0}}};

    localparam t_word C_ZERO = '0;
    localparam t_word C_ONE  = t_word'(64'd1 << F);
    localparam t_word C34    = t_word'(64'd3 << (F - 2));
    localparam t_word C14    = t_word'(64'd1 << (F - 2));
    localparam t_word C13    = t_word'(((64'd1 << F) + 64'd1) / 64'd3);
    localparam t_word C23    = t_word'(((64'd1 << (F + 1)) + 64'd1) / 64'd3);

    localparam t_ureg RST_GRAVITY = 47'd673292817216;
    localparam t_ureg RST_SLOPE   = 47'd3447862306;
    localparam t_ureg RST_BED     = 47'd250180127;
    localparam t_ureg RST_ROLLER  = 47'd24051817;
    localparam t_ureg RST_WALL    = 47'd1564055290511;
    localparam t_ureg RST_DRY     = 47'd7;

    localparam logic [2:0] CFG_GRAVITY = 3'd0;
    localparam logic [2:0] CFG_SLOPE   = 3'd1;
    localparam logic [2:0] CFG_BED     = 3'd2;
    localparam logic [2:0] CFG_ROLLER  = 3'd3;
    localparam logic [2:0] CFG_WALL    = 3'd4;
    localparam logic [2:0] CFG_DRY     = 3'd5;

    typedef struct packed {
        t_word velocity;
        t_ureg depth;
        t_word energy;
        t_ureg time_step;
    } t_in;

    typedef struct packed {
        t_word new_velocity;
        t_word new_energy;
        logic  fault;
    } t_out;

    typedef struct packed {
        t_ureg gravity_eff;
        t_ureg bed_slope;
        t_ureg bed_friction;
        t_ureg roller_friction;
        t_ureg wall_dissipation;
        t_ureg dry_depth;
    } t_cfg;

    typedef struct packed {
        t_word u0;
        t_word e0;
        t_word up;
        t_word ep;
        t_word dt;
        t_word h;
        t_word gs;
        t_word gh;
        t_word au;
        t_word m;
        t_word f;
        t_word uu;
        t_word phi;
        t_word ce;
        t_word cube;
        t_word g;
        t_word ua;
        t_word ea;
        logic  dry;
        logic  pz;
        logic  fault;
    } t_ctx;

    typedef struct packed {
        logic  ovf;
        t_word val;
    } t_sres;

    function automatic t_word widen(t_ureg x);
        widen = t_word'({1'b0, x});
    endfunction

    function automatic t_sres sat_add(t_word a, t_word b);
        logic [W:0] s;
        t_sres r;
        s = {a[W-1], a} + {b[W-1], b};
        r.ovf = s[W] ^ s[W-1];
        r.val = r.ovf ? (s[W] ? MINV : MAXV) : t_word'(s[W-1:0]);
        return r;
    endfunction

    function automatic t_sres sat_sub(t_word a, t_word b);
        logic [W:0] s;
        t_sres r;
        s = {a[W-1], a} - {b[W-1], b};
        r.ovf = s[W] ^ s[W-1];
        r.val = r.ovf ? (s[W] ? MINV : MAXV) : t_word'(s[W-1:0]);
        return r;
    endfunction

    function automatic t_sres abs_sat(t_word a);
        t_sres r;
        r.ovf = (a == MINV);
        r.val = r.ovf ? MAXV : (a[W-1] ? -a : a);
        return r;
    endfunction

endpackage

// ----- hw/rtl/rwfrk_mul.sv -----
// pipelined saturating fixed-point multiplier, five register stages
// depends on rwfrk_pkg; carries the cell context alongside the operands
module rwfrk_mul import rwfrk_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_vld,
    input  t_word i_a,
    input  t_word i_b,
    input  t_ctx  i_ctx,
    output logic  o_vld,
    output t_word o_res,
    output logic  o_ovf,
    output t_ctx  o_ctx
);

    logic          r1_vld, r2_vld, r3_vld, r4_vld, r5_vld;
    t_word         r1_a, r1_b;
    t_ctx          r1_ctx, r2_ctx, r3_ctx, r4_ctx, r5_ctx;
    logic          r2_neg, r3_neg, r4_neg;
    logic [W-1:0]  r2_x, r2_y;
    logic [W-1:0]  r3_p00, r3_p01, r3_p10, r3_p11;
    logic [W2-1:0] r4_p;
    t_word         r5_res;
    logic          r5_ovf;

    logic [W-1:0]  n_x, n_y, w_ua, w_ub;
    logic [W2-1:0] n_p;
    logic [QB-1:0] w_q;
    t_word         n_res;
    logic          n_ovf;

    always_comb begin
        w_ua = r1_a;
        w_ub = r1_b;
        n_x  = w_ua[W-1] ? (~w_ua + W'(1)) : w_ua;
        n_y  = w_ub[W-1] ? (~w_ub + W'(1)) : w_ub;
        n_p  = W2'(r3_p00) + (W2'(r3_p01) << H) + (W2'(r3_p10) << H) + (W2'(r3_p11) << W);
        w_q  = QB'(r4_p[W2-1:F]);
        if (r4_neg && (|r4_p[F-1:0])) begin
            w_q = w_q + QB'(1);
        end
        if (r4_neg) begin
            n_ovf = w_q > (QB'(1) << (W-1));
            n_res = n_ovf ? MINV : t_word'(-w_q[W-1:0]);
        end else begin
            n_ovf = w_q > ((QB'(1) << (W-1)) - QB'(1));
            n_res = n_ovf ? MAXV : t_word'(w_q[W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
        end else if (i_en) begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_a   <= i_a;
            r1_b   <= i_b;
            r1_ctx <= i_ctx;
            r2_x   <= n_x;
            r2_y   <= n_y;
            r2_neg <= r1_a[W-1] ^ r1_b[W-1];
            r2_ctx <= r1_ctx;
            r3_p00 <= r2_x[H-1:0] * r2_y[H-1:0];
            r3_p01 <= r2_x[H-1:0] * r2_y[W-1:H];
            r3_p10 <= r2_x[W-1:H] * r2_y[H-1:0];
            r3_p11 <= r2_x[W-1:H] * r2_y[W-1:H];
            r3_neg <= r2_neg;
            r3_ctx <= r2_ctx;
            r4_p   <= n_p;
            r4_neg <= r3_neg;
            r4_ctx <= r3_ctx;
            r5_res <= n_res;
            r5_ovf <= n_ovf;
            r5_ctx <= r4_ctx;
        end
    end

    assign o_vld = r5_vld;
    assign o_res = r5_res;
    assign o_ovf = r5_ovf;
    assign o_ctx = r5_ctx;

endmodule

// ----- hw/rtl/rwfrk_div.sv -----
// pipelined saturating fixed-point divider, one quotient bit per stage
// depends on rwfrk_pkg; carries the cell context alongside the operands
module rwfrk_div import rwfrk_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_vld,
    input  t_word i_a,
    input  t_word i_b,
    input  t_ctx  i_ctx,
    output logic  o_vld,
    output t_word o_res,
    output logic  o_ovf,
    output t_ctx  o_ctx
);

    logic         r1_vld;
    t_word        r1_a, r1_b;
    t_ctx         r1_ctx;

    logic         r_vld [QD+1];
    logic [W-1:0] r_rem [QD+1];
    logic [QD-1:0] r_q  [QD+1];
    logic [XL-1:0] r_xl [QD+1];
    logic [W-1:0] r_d   [QD+1];
    logic         r_neg [QD+1];
    logic         r_dz  [QD+1];
    logic         r_ov  [QD+1];
    t_ctx         r_ctx [QD+1];

    logic         r_out_vld, r_out_ovf;
    t_word        r_out_res;
    t_ctx         r_out_ctx;

    logic [W-1:0] w_x, w_d, w_ua, w_ub;
    t_word        n_res;
    logic         n_ovf;
    logic [QD-1:0] w_qf;

    always_comb begin
        w_ua = r1_a;
        w_ub = r1_b;
        w_x  = w_ua[W-1] ? (~w_ua + W'(1)) : w_ua;
        w_d  = w_ub[W-1] ? (~w_ub + W'(1)) : w_ub;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld   <= 1'b0;
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r1_vld   <= i_vld;
            r_vld[0] <= r1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_a     <= i_a;
            r1_b     <= i_b;
            r1_ctx   <= i_ctx;
            r_rem[0] <= w_x >> XL;
            r_q[0]   <= '0;
            r_xl[0]  <= w_x[XL-1:0];
            r_d[0]   <= w_d;
            r_neg[0] <= r1_a[W-1] ^ r1_b[W-1];
            r_dz[0]  <= (w_d == '0);
            r_ov[0]  <= {{XL{1'b0}}, w_x} >= {w_d, {XL{1'b0}}};
            r_ctx[0] <= r1_ctx;
        end
    end

    for (genvar j = 0; j < QD; j++) begin : g_iter
        logic [W:0] w_t;
        logic       w_ge;
        assign w_t  = {r_rem[j], r_xl[j][XL-1]};
        assign w_ge = w_t >= {1'b0, r_d[j]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[j+1] <= r_vld[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j+1] <= w_ge ? W'(w_t - {1'b0, r_d[j]}) : W'(w_t);
                r_q[j+1]   <= {r_q[j][QD-2:0], w_ge};
                r_xl[j+1]  <= {r_xl[j][XL-2:0], 1'b0};
                r_d[j+1]   <= r_d[j];
                r_neg[j+1] <= r_neg[j];
                r_dz[j+1]  <= r_dz[j];
                r_ov[j+1]  <= r_ov[j];
                r_ctx[j+1] <= r_ctx[j];
            end
        end
    end

    always_comb begin
        w_qf = r_q[QD];
        if (r_dz[QD]) begin
            n_ovf = 1'b1;
            n_res = '0;
        end else if (r_ov[QD]) begin
            n_ovf = 1'b1;
            n_res = r_neg[QD] ? MINV : MAXV;
        end else if (r_neg[QD]) begin
            n_ovf = w_qf > (QD'(1) << (W-1));
            n_res = n_ovf ? MINV : t_word'(-w_qf[W-1:0]);
        end else begin
            n_ovf = w_qf > ((QD'(1) << (W-1)) - QD'(1));
            n_res = n_ovf ? MAXV : t_word'(w_qf[W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_en) begin
            r_out_vld <= r_vld[QD];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out_res <= n_res;
            r_out_ovf <= n_ovf;
            r_out_ctx <= r_ctx[QD];
        end
    end

    assign o_vld = r_out_vld;
    assign o_res = r_out_res;
    assign o_ovf = r_out_ovf;
    assign o_ctx = r_out_ctx;

endmodule

// ----- hw/rtl/rwfrk_stage.sv -----
// one runge-kutta stage: friction sources of momentum and energy, then the weighted update
// depends on rwfrk_pkg, rwfrk_mul and rwfrk_div
module rwfrk_stage import rwfrk_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  t_cfg  i_cfg,
    input  t_word i_ca,
    input  t_word i_cb,
    input  logic  i_vld,
    input  t_ctx  i_ctx,
    output logic  o_vld,
    output t_ctx  o_ctx
);

    localparam int NS = 20;

    localparam int ST_MCF  = 0;
    localparam int ST_MAU  = 1;
    localparam int ST_DRAG = 2;
    localparam int ST_UU   = 3;
    localparam int ST_NUMH = 4;
    localparam int ST_PHI  = 5;
    localparam int ST_RAT  = 6;
    localparam int ST_ROLL = 7;
    localparam int ST_CUBE = 8;
    localparam int ST_LM   = 9;
    localparam int ST_LOSS = 10;
    localparam int ST_GSU  = 11;
    localparam int ST_DTF  = 12;
    localparam int ST_DTG  = 13;
    localparam int ST_BF   = 14;
    localparam int ST_BG   = 15;
    localparam int ST_AU0  = 16;
    localparam int ST_BUP  = 17;
    localparam int ST_AE0  = 18;
    localparam int ST_BEP  = 19;

    t_ctx  w_cin  [NS+1];
    logic  w_vin  [NS+1];
    t_ctx  w_cout [NS];
    logic  w_vout [NS];
    t_word w_a    [NS];
    t_word w_b    [NS];
    t_word w_r    [NS];
    logic  w_ovf  [NS];
    t_word w_cf, w_cr, w_pw;

    assign w_cf = widen(i_cfg.bed_friction);
    assign w_cr = widen(i_cfg.roller_friction);
    assign w_pw = widen(i_cfg.wall_dissipation);

    assign w_vin[0] = i_vld;

    for (genvar k = 0; k < NS; k++) begin : g_step
        if (k == ST_DRAG || k == ST_NUMH || k == ST_PHI || k == ST_RAT || k == ST_LOSS)
        begin : g_div
            rwfrk_div u_div (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_en   (i_en),
                .i_vld  (w_vin[k]),
                .i_a    (w_a[k]),
                .i_b    (w_b[k]),
                .i_ctx  (w_cin[k]),
                .o_vld  (w_vout[k]),
                .o_res  (w_r[k]),
                .o_ovf  (w_ovf[k]),
                .o_ctx  (w_cout[k])
            );
        end else begin : g_mul
            rwfrk_mul u_mul (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_en   (i_en),
                .i_vld  (w_vin[k]),
                .i_a    (w_a[k]),
                .i_b    (w_b[k]),
                .i_ctx  (w_cin[k]),
                .o_vld  (w_vout[k]),
                .o_res  (w_r[k]),
                .o_ovf  (w_ovf[k]),
                .o_ctx  (w_cout[k])
            );
        end
        assign w_vin[k+1] = w_vout[k];
    end

    // operand selection
    always_comb begin
        for (int k = 0; k < NS; k++) begin
            w_a[k] = '0;
            w_b[k] = '0;
            case (k)
                ST_MCF:  begin w_a[k] = w_cf;           w_b[k] = w_cin[k].up;   end
                ST_MAU:  begin w_a[k] = w_cin[k].m;     w_b[k] = w_cin[k].au;   end
                ST_DRAG: begin w_a[k] = w_cin[k].m;     w_b[k] = w_cin[k].h;    end
                ST_UU:   begin w_a[k] = w_cin[k].au;    w_b[k] = w_cin[k].au;   end
                ST_NUMH: begin w_a[k] = w_cin[k].m;     w_b[k] = w_cin[k].h;    end
                ST_PHI:  begin w_a[k] = w_cin[k].m;     w_b[k] = w_cin[k].h;    end
                ST_RAT:  begin w_a[k] = w_cin[k].m;     w_b[k] = w_cin[k].phi;  end
                ST_ROLL: begin w_a[k] = w_cr;           w_b[k] = w_cin[k].m;    end
                ST_CUBE: begin w_a[k] = w_cin[k].uu;    w_b[k] = w_cin[k].au;   end
                ST_LM:   begin w_a[k] = w_cin[k].ce;    w_b[k] = w_cin[k].cube; end
                ST_LOSS: begin w_a[k] = w_cin[k].m;     w_b[k] = w_cin[k].h;    end
                ST_GSU:  begin w_a[k] = w_cin[k].gs;    w_b[k] = w_cin[k].up;   end
                ST_DTF:  begin w_a[k] = w_cin[k].dt;    w_b[k] = w_cin[k].f;    end
                ST_DTG:  begin w_a[k] = w_cin[k].dt;    w_b[k] = w_cin[k].g;    end
                ST_BF:   begin w_a[k] = i_cb;           w_b[k] = w_cin[k].f;    end
                ST_BG:   begin w_a[k] = i_cb;           w_b[k] = w_cin[k].g;    end
                ST_AU0:  begin w_a[k] = i_ca;           w_b[k] = w_cin[k].u0;   end
                ST_BUP:  begin w_a[k] = i_cb;           w_b[k] = w_cin[k].up;   end
                ST_AE0:  begin w_a[k] = i_ca;           w_b[k] = w_cin[k].e0;   end
                ST_BEP:  begin w_a[k] = i_cb;           w_b[k] = w_cin[k].ep;   end
                default: begin w_a[k] = '0;             w_b[k] = '0;            end
            endcase
        end
    end

    // result write-back and fault collection between steps
    always_comb begin
        t_sres s1, s2, s3;
        t_ctx  c;
        logic  wet, live;
        s1 = abs_sat(i_ctx.up);
        c  = i_ctx;
        c.au = s1.val;
        c.fault = c.fault | (s1.ovf & ~c.dry);
        w_cin[0] = c;
        for (int k = 0; k < NS; k++) begin
            c    = w_cout[k];
            wet  = ~c.dry;
            live = wet & ~c.pz;
            s1 = '0;
            s2 = '0;
            s3 = '0;
            case (k)
                ST_MCF, ST_MAU, ST_NUMH: begin
                    c.m = w_r[k];
                    c.fault = c.fault | (w_ovf[k] & wet);
                end
                ST_DRAG: begin
                    s1 = sat_sub(c.gs, w_r[k]);
                    c.f = c.dry ? '0 : s1.val;
                    c.fault = c.fault | ((w_ovf[k] | s1.ovf) & wet);
                end
                ST_UU: begin
                    c.uu = w_r[k];
                    s1 = sat_add(c.ep, c.ep);
                    s2 = sat_sub(s1.val, c.gh);
                    s3 = sat_sub(s2.val, w_r[k]);
                    c.m = s3.val;
                    c.fault = c.fault | ((w_ovf[k] | s1.ovf | s2.ovf | s3.ovf) & wet);
                end
                ST_PHI: begin
                    c.phi = w_r[k];
                    c.pz  = (w_r[k] == '0);
                    s1 = sat_sub(w_r[k], w_pw);
                    c.m = s1.val;
                    c.fault = c.fault | ((w_ovf[k] | c.pz) & wet) | (s1.ovf & wet & ~c.pz);
                end
                ST_RAT: begin
                    c.m = w_r[k];
                    c.fault = c.fault | (w_ovf[k] & live);
                end
                ST_ROLL: begin
                    s1 = sat_add(w_cf, w_r[k]);
                    c.ce = c.pz ? w_cf : s1.val;
                    c.fault = c.fault | ((w_ovf[k] | s1.ovf) & live);
                end
                ST_CUBE: begin
                    c.cube = w_r[k];
                    c.fault = c.fault | (w_ovf[k] & wet);
                end
                ST_LM: begin
                    c.m = w_r[k];
                    c.fault = c.fault | (w_ovf[k] & wet);
                end
                ST_LOSS: begin
                    c.ce = w_r[k];
                    c.fault = c.fault | (w_ovf[k] & wet);
                end
                ST_GSU: begin
                    s1 = sat_sub(w_r[k], c.ce);
                    c.g = c.dry ? '0 : s1.val;
                    c.fault = c.fault | ((w_ovf[k] | s1.ovf) & wet);
                end
                ST_DTF, ST_BF: begin
                    c.f = w_r[k];
                    c.fault = c.fault | w_ovf[k];
                end
                ST_DTG, ST_BG: begin
                    c.g = w_r[k];
                    c.fault = c.fault | w_ovf[k];
                end
                ST_AU0: begin
                    c.ua = w_r[k];
                    c.fault = c.fault | w_ovf[k];
                end
                ST_BUP: begin
                    s1 = sat_add(c.ua, w_r[k]);
                    s2 = sat_add(s1.val, c.f);
                    c.up = s2.val;
                    c.fault = c.fault | w_ovf[k] | s1.ovf | s2.ovf;
                end
                ST_AE0: begin
                    c.ea = w_r[k];
                    c.fault = c.fault | w_ovf[k];
                end
                ST_BEP: begin
                    s1 = sat_add(c.ea, w_r[k]);
                    s2 = sat_add(s1.val, c.g);
                    c.ep = s2.val;
                    c.fault = c.fault | w_ovf[k] | s1.ovf | s2.ovf;
                end
                default: begin
                    c.fault = c.fault | w_ovf[k];
                end
            endcase
            w_cin[k+1] = c;
        end
    end

    assign o_vld = w_vin[NS];
    assign o_ctx = w_cin[NS];

endmodule

// ----- hw/rtl/roll_wave_friction_rk3_cell_update_core.sv -----
// top level of the friction rk3 cell update: config registers, entry products, three stages
// depends on rwfrk_pkg, rwfrk_mul and rwfrk_stage
//
// Input channel i_valid/i_data/o_stall carries one cell (velocity, depth, energy, time step);
// a transfer happens on a rising edge with i_valid high and o_stall low. Output channel
// o_valid/o_data/i_stall returns the updated velocity, energy and the fault flag, one result
// per cell, in arrival order.
// Throughput is one cell per clock unless i_stall freezes the pipeline. Each cell passes
// through two entry multiplies, then three stages of 15 multiplies and 5 dividers (one quotient
// bit per register stage), then the output register.
// When the receiver holds i_stall while a result waits in the output register, the whole
// pipeline freezes and o_stall goes high; nothing is dropped or repeated.
// Configuration writes use i_cfg_valid/o_cfg_ready with a register index; o_cfg_ready is always
// high and indexes past the register list are ignored. Write only while the block is empty.
// Synchronous reset clears all valid bits and restores the default coefficients; there is no
// clearing pass, so cells are accepted on the first cycle after reset.
module roll_wave_friction_rk3_cell_update_core import rwfrk_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_in        i_data,
    output logic       o_stall,
    output logic       o_valid,
    output t_out       o_data,
    input  logic       i_stall,
    input  logic       i_cfg_valid,
    input  logic [2:0] i_cfg_index,
    input  t_ureg      i_cfg_data,
    output logic       o_cfg_ready
);

    t_cfg  r_cfg;
    logic  r_out_valid;
    t_out  r_out_data;

    logic  w_en;
    t_ctx  w_entry, w_gs_out, w_gh_in, w_gh_out, w_s1_in;
    logic  w_gs_vld, w_gh_vld;
    t_word w_gs_res, w_gh_res;
    logic  w_gs_ovf, w_gh_ovf;
    logic  w_v1, w_v2, w_v3;
    t_ctx  w_c1, w_c2, w_c3;

    assign w_en        = ~(r_out_valid & i_stall);
    assign o_stall     = ~w_en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gravity_eff      <= RST_GRAVITY;
            r_cfg.bed_slope        <= RST_SLOPE;
            r_cfg.bed_friction     <= RST_BED;
            r_cfg.roller_friction  <= RST_ROLLER;
            r_cfg.wall_dissipation <= RST_WALL;
            r_cfg.dry_depth        <= RST_DRY;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_GRAVITY: r_cfg.gravity_eff      <= i_cfg_data;
                CFG_SLOPE:   r_cfg.bed_slope        <= i_cfg_data;
                CFG_BED:     r_cfg.bed_friction     <= i_cfg_data;
                CFG_ROLLER:  r_cfg.roller_friction  <= i_cfg_data;
                CFG_WALL:    r_cfg.wall_dissipation <= i_cfg_data;
                CFG_DRY:     r_cfg.dry_depth        <= i_cfg_data;
                default:     r_cfg                  <= r_cfg;
            endcase
        end
    end

    always_comb begin
        w_entry       = '0;
        w_entry.u0    = i_data.velocity;
        w_entry.up    = i_data.velocity;
        w_entry.e0    = i_data.energy;
        w_entry.ep    = i_data.energy;
        w_entry.dt    = widen(i_data.time_step);
        w_entry.h     = widen(i_data.depth);
        w_entry.dry   = i_data.depth <= r_cfg.dry_depth;
        w_entry.fault = 1'b0;
    end

    rwfrk_mul u_gs (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_vld  (i_valid),
        .i_a    (widen(r_cfg.gravity_eff)),
        .i_b    (widen(r_cfg.bed_slope)),
        .i_ctx  (w_entry),
        .o_vld  (w_gs_vld),
        .o_res  (w_gs_res),
        .o_ovf  (w_gs_ovf),
        .o_ctx  (w_gs_out)
    );

    always_comb begin
        w_gh_in       = w_gs_out;
        w_gh_in.gs    = w_gs_res;
        w_gh_in.fault = w_gs_out.fault | (w_gs_ovf & ~w_gs_out.dry);
    end

    rwfrk_mul u_gh (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_vld  (w_gs_vld),
        .i_a    (widen(r_cfg.gravity_eff)),
        .i_b    (w_gh_in.h),
        .i_ctx  (w_gh_in),
        .o_vld  (w_gh_vld),
        .o_res  (w_gh_res),
        .o_ovf  (w_gh_ovf),
        .o_ctx  (w_gh_out)
    );

    always_comb begin
        w_s1_in       = w_gh_out;
        w_s1_in.gh    = w_gh_res;
        w_s1_in.fault = w_gh_out.fault | (w_gh_ovf & ~w_gh_out.dry);
    end

    rwfrk_stage u_stage1 (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_cfg  (r_cfg),
        .i_ca   (C_ZERO),
        .i_cb   (C_ONE),
        .i_vld  (w_gh_vld),
        .i_ctx  (w_s1_in),
        .o_vld  (w_v1),
        .o_ctx  (w_c1)
    );

    rwfrk_stage u_stage2 (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_cfg  (r_cfg),
        .i_ca   (C34),
        .i_cb   (C14),
        .i_vld  (w_v1),
        .i_ctx  (w_c1),
        .o_vld  (w_v2),
        .o_ctx  (w_c2)
    );

    rwfrk_stage u_stage3 (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_en   (w_en),
        .i_cfg  (r_cfg),
        .i_ca   (C13),
        .i_cb   (C23),
        .i_vld  (w_v2),
        .i_ctx  (w_c2),
        .o_vld  (w_v3),
        .o_ctx  (w_c3)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_data.new_velocity <= w_c3.up;
            r_out_data.new_energy   <= w_c3.ep;
            r_out_data.fault        <= w_c3.fault;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

    a_frozen_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(w_v3))
        else $error("pipeline tail moved while frozen");

    a_rise_needs_en: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_en))
        else $error("result appeared while pipeline frozen");

    a_tail_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && w_v3) |=> r_out_valid)
        else $error("finished cell lost at output register");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_out_valid && i_stall))
        else $error("input held off with no waiting result");

endmodule
